// ----- design/dcbg_pkg.sv -----
package dcbg_pkg;

    localparam int SAMPLE_BITS_DEF      = 16;
    localparam int FILTER_FRAC_BITS_DEF = 16;

    // Integer bits of the filter state, so y1 is signed Q31.F.
    localparam int Y_INT_BITS      = 32;
    localparam int COEF_BITS       = 16;
    localparam int ALPHA_FRAC_BITS = 16;
    localparam int GAIN_FRAC_BITS  = 8;
    localparam int CNT_BITS        = 16;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DC_ALPHA      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INPUT_GAIN    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DISCARD_COUNT = 2'd2;

    localparam logic [COEF_BITS-1:0] DC_ALPHA_RST      = 16'd65208;
    localparam logic [COEF_BITS-1:0] INPUT_GAIN_RST    = 16'd256;
    localparam logic [CNT_BITS-1:0]  DISCARD_COUNT_RST = 16'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FB_LO,
        ST_FB_HI,
        ST_FB_ADD,
        ST_FILT,
        ST_ABS,
        ST_G_LO,
        ST_G_HI,
        ST_G_ADD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic mul_en;
        logic mul_gain;
        logic mul_hi;
        logic acc_load;
        logic acc_add;
        logic filt_upd;
        logic abs_upd;
        logic out_load;
    } t_ctrl;

endpackage

// ----- design/dcbg_if.sv -----
interface dcbg_cfg_if;
    import dcbg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

interface dcbg_smp_in_if #(
    parameter int SAMPLE_BITS = dcbg_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          restart;

    modport source(output valid, sample_in, restart, input ready);
    modport sink(input valid, sample_in, restart, output ready);
endinterface

interface dcbg_smp_out_if #(
    parameter int SAMPLE_BITS = dcbg_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;

    modport source(output valid, sample_out, clipped, input ready);
    modport sink(input valid, sample_out, clipped, output ready);
endinterface

// ----- design/dc_block_gain_clip_conditioner_unit.sv -----
// An accepted sample passes FB_LO, FB_HI, FB_ADD, FILT, ABS, G_LO, G_HI, G_ADD and OUT
// before its result shows valid; the input is not ready until OUT hands the result
// on; a dropped sample leaves the unit idle. One shared multiplier is used four times
// per sample (two chunks each for feedback and gain), with its accumulate passes.
// Reset (synchronous, active low) restores the register defaults, clears the discard
// counter and filter history, and empties the output register.
module dc_block_gain_clip_conditioner_unit #(
    parameter int SAMPLE_BITS      = dcbg_pkg::SAMPLE_BITS_DEF,
    parameter int FILTER_FRAC_BITS = dcbg_pkg::FILTER_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dcbg_cfg_if.sink              i_cfg,
    dcbg_smp_in_if.sink           i_smp,
    dcbg_smp_out_if.source        o_smp
);
    import dcbg_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int F      = FILTER_FRAC_BITS;
    localparam int YB     = Y_INT_BITS + F;
    localparam int CH     = (YB + 1) / 2;
    localparam int HB     = YB - CH;
    localparam int AW     = YB + COEF_BITS + 1;
    localparam int Q_BITS = AW - F - GAIN_FRAC_BITS;

    localparam logic [Q_BITS-1:0] LIM_POS = Q_BITS'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic [Q_BITS-1:0] LIM_NEG = Q_BITS'(64'd1 << (SB - 1));

    logic [COEF_BITS-1:0]   r_alpha;
    logic [COEF_BITS-1:0]   r_gain;
    logic [CNT_BITS-1:0]    r_discard;
    logic [CNT_BITS-1:0]    r_cnt;
    logic signed [SB-1:0]   r_x;
    logic signed [SB-1:0]   r_x1;
    logic signed [YB-1:0]   r_y1;
    logic [YB-1:0]          r_mag;
    logic                   r_neg;
    logic                   r_out_valid;
    logic signed [SB-1:0]   r_out_sample;
    logic                   r_out_clip;

    t_ctrl                  ctrl;
    logic                   idle;
    logic                   in_fire;
    logic [CNT_BITS-1:0]    cnt_eff;
    logic                   drop;
    logic                   start;
    logic                   out_free;

    logic [COEF_BITS-1:0]   coef;
    logic signed [CH:0]     chunk;
    logic signed [AW-1:0]   acc;

    logic signed [YB:0]     fb;
    logic signed [SB:0]     diff;
    logic signed [YB+1:0]   y_sum;
    logic signed [YB-1:0]   y_sat;

    logic [Q_BITS-1:0]      q;
    logic [Q_BITS-1:0]      lim;
    logic                   clip;
    logic [Q_BITS-1:0]      q_sat;
    logic [SB-1:0]          q_low;
    logic [SB-1:0]          res;

    // Configuration port.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha   <= DC_ALPHA_RST;
            r_gain    <= INPUT_GAIN_RST;
            r_discard <= DISCARD_COUNT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DC_ALPHA:      r_alpha   <= COEF_BITS'(i_cfg.data);
                CFG_INPUT_GAIN:    r_gain    <= COEF_BITS'(i_cfg.data);
                CFG_DISCARD_COUNT: r_discard <= CNT_BITS'(i_cfg.data);
                default:           ;
            endcase
        end
    end

    // Input side: restart clears history before the drop decision is taken.
    assign i_smp.ready = idle;
    assign in_fire     = i_smp.valid & idle;
    assign cnt_eff     = i_smp.restart ? '0 : r_cnt;
    assign drop        = (cnt_eff < r_discard);
    assign start       = in_fire & ~drop;
    assign out_free    = ~r_out_valid | o_smp.ready;

    dcbg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .o_idle     (idle),
        .o_ctrl     (ctrl)
    );

    // Operand selection for the shared multiplier: the low chunk is unsigned,
    // the high chunk of y1 carries the sign, the magnitude chunks are unsigned.
    assign coef = ctrl.mul_gain ? r_gain : r_alpha;

    always_comb begin
        unique case ({ctrl.mul_gain, ctrl.mul_hi})
            2'b00:   chunk = $signed({1'b0, r_y1[CH-1:0]});
            2'b01:   chunk = $signed({{(CH + 1 - HB){r_y1[YB-1]}}, r_y1[YB-1:CH]});
            2'b10:   chunk = $signed({1'b0, r_mag[CH-1:0]});
            default: chunk = $signed({{(CH + 1 - HB){1'b0}}, r_mag[YB-1:CH]});
        endcase
    end

    dcbg_mac #(
        .CH (CH),
        .AW (AW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_coef  (coef),
        .i_chunk (chunk),
        .o_acc   (acc)
    );

    // Filter update: floor(alpha * y1 / 2^16) plus the scaled input difference.
    assign fb    = $signed(acc[AW-1:ALPHA_FRAC_BITS]);
    assign diff  = (SB + 1)'(r_x) - (SB + 1)'(r_x1);
    assign y_sum = ((YB + 2)'(diff) <<< F) + (YB + 2)'(fb);

    always_comb begin
        if ((y_sum[YB+1] == y_sum[YB]) && (y_sum[YB] == y_sum[YB-1])) begin
            y_sat = y_sum[YB-1:0];
        end else begin
            y_sat = {y_sum[YB+1], {(YB - 1){~y_sum[YB+1]}}};
        end
    end

    // Gain stage works on the magnitude so that the shift truncates toward zero.
    assign q     = acc[AW-1:F+GAIN_FRAC_BITS];
    assign lim   = r_neg ? LIM_NEG : LIM_POS;
    assign clip  = (q > lim);
    assign q_sat = clip ? lim : q;
    assign q_low = q_sat[SB-1:0];
    assign res   = r_neg ? (~q_low + 1'b1) : q_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_x1        <= '0;
            r_y1        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_cnt <= drop ? CNT_BITS'(cnt_eff + 1'b1) : cnt_eff;
                if (i_smp.restart) begin
                    r_x1 <= '0;
                    r_y1 <= '0;
                end
            end
            if (ctrl.filt_upd) begin
                r_y1 <= y_sat;
                r_x1 <= r_x;
            end
            if (ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_smp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x <= i_smp.sample_in;
        end
        if (ctrl.abs_upd) begin
            r_neg <= r_y1[YB-1];
            r_mag <= r_y1[YB-1] ? (~r_y1 + 1'b1) : r_y1;
        end
        if (ctrl.out_load) begin
            r_out_sample <= $signed(res);
            r_out_clip   <= clip;
        end
    end

    assign o_smp.valid      = r_out_valid;
    assign o_smp.sample_out = r_out_sample;
    assign o_smp.clipped    = r_out_clip;

endmodule

// ----- design/dcbg_mac.sv -----
module dcbg_mac #(
    parameter int CH = 24,
    parameter int AW = 65
) (
    input  logic                              i_clk,
    input  dcbg_pkg::t_ctrl                   i_ctrl,
    input  logic [dcbg_pkg::COEF_BITS-1:0]    i_coef,
    input  logic signed [CH:0]                i_chunk,
    output logic signed [AW-1:0]              o_acc
);
    import dcbg_pkg::*;

    localparam int PW = CH + COEF_BITS + 2;

    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] prod_ext;
    logic signed [AW-1:0] prod_shl;

    // The coefficient is unsigned, so it enters the signed product with a zero on top.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= $signed({1'b0, i_coef}) * i_chunk;
        end
    end

    assign prod_ext = AW'(r_prod);
    // Upper chunk products weigh 2^CH; bits beyond the accumulator cancel out.
    assign prod_shl = prod_ext << CH;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_load) begin
            r_acc <= prod_ext;
        end else if (i_ctrl.acc_add) begin
            r_acc <= r_acc + prod_shl;
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- design/dcbg_ctrl.sv -----
module dcbg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_out_free,
    output logic            o_idle,
    output dcbg_pkg::t_ctrl o_ctrl
);
    import dcbg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_start) n_state = ST_FB_LO;
            ST_FB_LO:  n_state = ST_FB_HI;
            ST_FB_HI:  n_state = ST_FB_ADD;
            ST_FB_ADD: n_state = ST_FILT;
            ST_FILT:   n_state = ST_ABS;
            ST_ABS:    n_state = ST_G_LO;
            ST_G_LO:   n_state = ST_G_HI;
            ST_G_HI:   n_state = ST_G_ADD;
            ST_G_ADD:  n_state = ST_OUT;
            ST_OUT:    if (i_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            ST_FB_LO: begin
                o_ctrl.mul_en = 1'b1;
            end
            ST_FB_HI: begin
                o_ctrl.mul_en   = 1'b1;
                o_ctrl.mul_hi   = 1'b1;
                o_ctrl.acc_load = 1'b1;
            end
            ST_FB_ADD: begin
                o_ctrl.acc_add = 1'b1;
            end
            ST_FILT: begin
                o_ctrl.filt_upd = 1'b1;
            end
            ST_ABS: begin
                o_ctrl.abs_upd = 1'b1;
            end
            ST_G_LO: begin
                o_ctrl.mul_en   = 1'b1;
                o_ctrl.mul_gain = 1'b1;
            end
            ST_G_HI: begin
                o_ctrl.mul_en   = 1'b1;
                o_ctrl.mul_gain = 1'b1;
                o_ctrl.mul_hi   = 1'b1;
                o_ctrl.acc_load = 1'b1;
            end
            ST_G_ADD: begin
                o_ctrl.acc_add = 1'b1;
            end
            ST_OUT: begin
                o_ctrl.out_load = i_out_free;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule

// ----- design/dcbg_checker.sv -----
module dcbg_props #(
    parameter int SAMPLE_BITS = dcbg_pkg::SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_out_sample,
    input logic                   i_out_clipped
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // No result rises right after an input: the multiplier runs first.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result appeared right after an input transaction");

    // A new result is only produced while a sample is being worked on.
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result produced while the input side was idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_sample) && $stable(i_out_clipped)))
        else $error("stalled output transaction changed");

endmodule

bind dc_block_gain_clip_conditioner_unit dcbg_props #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_dcbg_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_smp.valid),
    .i_in_ready    (i_smp.ready),
    .i_out_valid   (o_smp.valid),
    .i_out_ready   (o_smp.ready),
    .i_out_sample  (o_smp.sample_out),
    .i_out_clipped (o_smp.clipped)
);

// ----- tb/sv/dcbg_checker.sv -----
module dcbg_checker
    import dcbg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dcbg_cfg_if       i_cfg,
    dcbg_smp_in_if    i_smp,
    dcbg_smp_out_if   i_res,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int FB = FILTER_FRAC_BITS_DEF;
    localparam int YB = Y_INT_BITS + FILTER_FRAC_BITS_DEF;
    localparam int FW = YB + ALPHA_FRAC_BITS + 2;
    localparam int GW = YB + COEF_BITS;

    // Two guard bits above the Q31.F range so the sum can be clamped afterwards.
    localparam logic signed [YB+1:0] Y_MAX = {3'b000, {(YB-1){1'b1}}};
    localparam logic signed [YB+1:0] Y_MIN = {3'b111, {(YB-1){1'b0}}};

    typedef struct packed {
        logic signed [SB-1:0] sample_out;
        logic                 clipped;
    } t_conditioned;

    logic [COEF_BITS-1:0]    alpha_q0_16;
    logic [COEF_BITS-1:0]    gain_q8_8;
    logic [CNT_BITS-1:0]     discard_limit;
    logic [CNT_BITS-1:0]     dropped_cnt;
    logic signed [SB-1:0]    last_input;
    logic signed [YB-1:0]    last_filtered;

    t_conditioned conditioned_q[$];
    int           mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // Returns 1 and the conditioned sample when the input is not dropped.
    function automatic bit condition_sample(input logic signed [SB-1:0] x, input logic restart,
                                            output t_conditioned res);
        logic signed [FW-1:0]                 feedback_full;
        logic signed [YB+1:0]                 feedback;
        logic signed [YB+1:0]                 y;
        logic signed [YB+1:0]                 y_abs;
        logic signed [SB:0]                   step;
        logic [YB-1:0]                        mag;
        logic [GW-1:0]                        scaled;
        logic [SB:0]                          ceiling;
        logic [SB:0]                          q;
        logic                                 neg;
        if (restart) begin
            dropped_cnt   = '0;
            last_input    = '0;
            last_filtered = '0;
        end
        if (dropped_cnt < discard_limit) begin
            dropped_cnt = dropped_cnt + 1'b1;
            return 1'b0;
        end
        // An arithmetic shift of the exact product rounds toward minus infinity.
        feedback_full = FW'($signed({1'b0, alpha_q0_16})) * FW'(last_filtered);
        feedback      = (YB + 2)'(feedback_full >>> ALPHA_FRAC_BITS);
        step          = (SB + 1)'(x) - (SB + 1)'(last_input);
        y             = (YB + 2)'(step);
        y             = (y <<< FB) + feedback;
        if (y > Y_MAX) y = Y_MAX;
        if (y < Y_MIN) y = Y_MIN;
        last_input    = x;
        last_filtered = y[YB-1:0];

        neg     = y < 0;
        y_abs   = neg ? -y : y;
        mag     = y_abs[YB-1:0];
        scaled  = GW'(mag) * GW'(gain_q8_8);
        scaled  = scaled >> (FB + GAIN_FRAC_BITS);
        ceiling = neg ? (SB+1)'(1) << (SB-1) : ((SB+1)'(1) << (SB-1)) - 1'b1;
        res.clipped = scaled > GW'(ceiling);
        q = res.clipped ? ceiling : scaled[SB:0];
        q = neg ? -q : q;
        res.sample_out = q[SB-1:0];
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_conditioned want;
        if (!i_rst_n) begin
            alpha_q0_16   = DC_ALPHA_RST;
            gain_q8_8     = INPUT_GAIN_RST;
            discard_limit = DISCARD_COUNT_RST;
            dropped_cnt   = '0;
            last_input    = '0;
            last_filtered = '0;
            conditioned_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_DC_ALPHA:      alpha_q0_16   = i_cfg.data;
                    CFG_INPUT_GAIN:    gain_q8_8     = i_cfg.data;
                    CFG_DISCARD_COUNT: discard_limit = i_cfg.data;
                    default: ;
                endcase
            end
            // Results are checked before new samples, so a result never meets its own sample.
            if (i_res.valid && i_res.ready) begin
                if (conditioned_q.size() == 0) begin
                    $error("unexpected result: sample_out %0d, clipped %0b",
                           i_res.sample_out, i_res.clipped);
                    mismatch_count++;
                end else begin
                    want = conditioned_q.pop_front();
                    if (i_res.sample_out !== want.sample_out) begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               want.sample_out, i_res.sample_out);
                        mismatch_count++;
                    end
                    if (i_res.clipped !== want.clipped) begin
                        $error("clipped mismatch: expected %0b, actual %0b",
                               want.clipped, i_res.clipped);
                        mismatch_count++;
                    end
                end
            end
            if (i_smp.valid && i_smp.ready) begin
                if (condition_sample(i_smp.sample_in, i_smp.restart, want))
                    conditioned_q.push_back(want);
            end
        end
        o_pending <= conditioned_q.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
    import dcbg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1300;
    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm = 1'b0;
    int   fail_count;
    int   pending;
    int unsigned quiet_cycles = 0;

    dcbg_cfg_if     cfg();
    dcbg_smp_in_if  smp_in();
    dcbg_smp_out_if smp_out();

    dc_block_gain_clip_conditioner_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_smp   (smp_in),
        .o_smp   (smp_out)
    );

    dcbg_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_smp        (smp_in),
        .i_res        (smp_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((cfg.valid && cfg.ready) || (smp_in.valid && smp_in.ready) ||
            (smp_out.valid && smp_out.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Output side: after each transaction, optionally hold ready low for a while.
    initial begin : result_sink
        int unsigned stall;
        smp_out.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        repeat ($urandom_range(0, 14)) @(posedge i_clk);
        smp_out.ready <= 1'b1;
        forever begin
            do @(posedge i_clk); while (!(smp_out.valid && smp_out.ready));
            stall = calm ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                smp_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                smp_out.ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic signed [15:0] sample, input logic restart);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            smp_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_in.valid     <= 1'b1;
        smp_in.sample_in <= sample;
        smp_in.restart   <= restart;
        do @(posedge i_clk); while (!(smp_in.valid && smp_in.ready));
    endtask

    // Waits until every result is in, then lets a dropped sample finish as well.
    task automatic wait_idle();
        smp_in.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] alpha, input logic [15:0] gain,
                              input logic [15:0] discard);
        logic [CFG_IDX_BITS-1:0]  idx[4];
        logic [CFG_DATA_BITS-1:0] val[4];
        idx = '{CFG_DC_ALPHA, CFG_INPUT_GAIN, CFG_UNUSED, CFG_DISCARD_COUNT};
        val = '{alpha, gain, 16'($urandom), discard};
        for (int i = 0; i < 4; i++) begin
            // The unused index is only written now and then.
            if (idx[i] != CFG_UNUSED || $urandom_range(0, 2) == 0) begin
                cfg.valid <= 1'b1;
                cfg.index <= idx[i];
                cfg.data  <= val[i];
                do @(posedge i_clk); while (!(cfg.valid && cfg.ready));
            end
        end
        cfg.valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_sample(input int dc);
        int v;
        case ($urandom_range(0, 7))
            0, 1:    v = int'($urandom_range(0, 65535)) - 32768;
            2:       v = $urandom_range(0, 1) ? 32767 : -32768;
            default: v = dc + int'($urandom_range(0, 2000)) - 1000;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_alpha();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return DC_ALPHA_RST;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return INPUT_GAIN_RST;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(1, 1024));
        endcase
    endfunction

    initial begin : stimulus
        int sent;
        int len;
        int dc;
        logic restart;
        cfg.valid        <= 1'b0;
        cfg.index        <= CFG_DC_ALPHA;
        cfg.data         <= '0;
        smp_in.valid     <= 1'b0;
        smp_in.sample_in <= '0;
        smp_in.restart   <= 1'b0;
        i_rst_n          <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: full-scale steps in both directions and a restart mid-stream.
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b1);
        send_sample(16'sd1, 1'b0);
        wait_idle();

        // Largest coefficient and gain clip hard; zero coefficient and gain give silence.
        set_config(16'hFFFF, 16'hFFFF, 16'd0);
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd5, 1'b0);
        wait_idle();
        set_config(16'd0, 16'd0, 16'd0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);
        wait_idle();

        // Dropping: a restart sample can itself be dropped, and the counter holds at its limit.
        set_config(DC_ALPHA_RST, INPUT_GAIN_RST, 16'd2);
        send_sample(16'sd1000, 1'b1);
        send_sample(16'sd2000, 1'b0);
        send_sample(16'sd3000, 1'b0);
        send_sample(-16'sd3000, 1'b0);
        send_sample(16'sd700, 1'b1);
        send_sample(16'sd800, 1'b0);
        send_sample(16'sd900, 1'b0);
        wait_idle();

        // Lowering the limit below the count already dropped ends the dropping at once.
        set_config(DC_ALPHA_RST, INPUT_GAIN_RST, 16'd5);
        send_sample(16'sd1234, 1'b1);
        send_sample(16'sd4321, 1'b0);
        wait_idle();
        set_config(DC_ALPHA_RST, INPUT_GAIN_RST, 16'd1);
        send_sample(16'sd10000, 1'b0);
        send_sample(-16'sd10000, 1'b0);
        wait_idle();

        // Largest limit: every sample is dropped, restarts included.
        set_config(16'($urandom), 16'($urandom), 16'hFFFF);
        calm = 1'b1;
        for (int k = 0; k < 40; k++)
            send_sample(pick_sample(0), $urandom_range(0, 9) == 0);
        wait_idle();
        set_config(DC_ALPHA_RST, INPUT_GAIN_RST, 16'd0);
        send_sample(16'sd300, 1'b0);
        wait_idle();

        // Random recordings: mostly opening with a restart, then a DC offset with noise and occasional bursts.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            set_config(pick_alpha(), pick_gain(),
                       $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 8)));
            calm = ($urandom_range(0, 3) == 0);
            len  = $urandom_range(40, 140);
            dc   = int'($urandom_range(0, 40000)) - 20000;
            for (int k = 0; k < len; k++) begin
                restart = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 49) == 0);
                if (restart)
                    dc = int'($urandom_range(0, 40000)) - 20000;
                send_sample(pick_sample(dc), restart);
                sent++;
            end
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/dcbg_pkg.sv
design/dcbg_if.sv
design/dcbg_mac.sv
design/dcbg_ctrl.sv
design/dc_block_gain_clip_conditioner_unit.sv
design/dcbg_checker.sv
tb/sv/dcbg_checker.sv
tb/sv/tb_top.sv
